### rtl/sths_pkg.sv
// Package for the half-step stepper speed drive.
// Shared types, register codes, scale constants and the half-step pattern table.
// No dependencies.
`timescale 1ns / 1ps

package sths_pkg;

   // Converter scale
   localparam logic [9:0] MID_SCALE  = 10'd512;
   localparam logic [9:0] FULL_SCALE = 10'd1023;

   // Half-step sequence
   localparam int HALF_STEPS = 8;

   // Register reset values
   localparam logic [9:0]  DEAD_BAND_RST = 10'd100;
   localparam logic [12:0] SLOWEST_RST   = 13'd4500;
   localparam logic [12:0] FASTEST_RST   = 13'd1000;

   // Register indexes
   typedef enum logic [1:0] {
      REG_DEAD_BAND = 2'd0,
      REG_SLOWEST   = 2'd1,
      REG_FASTEST   = 2'd2
   } reg_index_type;

   // Direction codes
   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   // Configuration registers as seen by the front end
   typedef struct packed {
      logic [9:0]  dead_band;
      logic [12:0] slowest_delay_us;
      logic [12:0] fastest_delay_us;
   } cfg_type;

   // One classified request waiting for the back end
   typedef struct packed {
      logic [12:0] hold_us;
      dir_type     direction;
   } step_entry_type;

   // Half-step coil pattern table, counter-clockwise order
   function automatic logic [3:0] half_step_pattern(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0:    pat = 4'b1000;
         3'd1:    pat = 4'b1100;
         3'd2:    pat = 4'b0100;
         3'd3:    pat = 4'b0110;
         3'd4:    pat = 4'b0010;
         3'd5:    pat = 4'b0011;
         3'd6:    pat = 4'b0001;
         default: pat = 4'b1001;
      endcase
      return pat;
   endfunction

endpackage

### rtl/stepper_half_step_speed_drive_top.sv
// Channel    Direction  Handshake              Payload
// req        in         req_tvalid/req_tready   tdata[9:0] pot_sample
// rsp        out        rsp_tvalid/rsp_tready   tdata coil_pattern, hold_us; tuser; tlast
// csr        in         csr_valid/csr_ready     csr_index, csr_data
//
// A turn request gives eight responses; a stop gives one.
// The front end handles a turn request in steps (operand load, multiply,
// radix-8 divide), so the back end's response sequence sets the sustained rate.
// The first response passes the front-end states, the queue and the response register.
// Reset is synchronous and restores the register defaults; no clearing pass.
// A two-entry queue lets the front end accept while the response side stalls.
`timescale 1ns / 1ps

module stepper_half_step_speed_drive_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] pot_sample, [15:10] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] coil_pattern, [16:4] hold_us, [23:17] zero
   output logic [1:0]  rsp_tuser,   // [1:0] direction
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import sths_pkg::*;

   cfg_type        cfg_ff;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;
   step_entry_type push_entry;
   step_entry_type head;
   logic [3:0]     coil_pattern;
   logic [12:0]    hold_us;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_band        <= DEAD_BAND_RST;
         cfg_ff.slowest_delay_us <= SLOWEST_RST;
         cfg_ff.fastest_delay_us <= FASTEST_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEAD_BAND: cfg_ff.dead_band        <= csr_data[9:0];
            REG_SLOWEST:   cfg_ff.slowest_delay_us <= csr_data;
            REG_FASTEST:   cfg_ff.fastest_delay_us <= csr_data;
            default:       ;
         endcase
      end
   end

   // Classification and hold-time mapping
   sths_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .pot_sample (req_tdata[9:0]),
      .push       (push),
      .queue_full (queue_full),
      .push_entry (push_entry)
   );

   // Decoupling queue
   sths_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // Step sequencing and response register
   sths_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (queue_empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .coil_pattern (coil_pattern),
      .hold_us      (hold_us),
      .direction    (rsp_tuser),
      .last         (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, hold_us, coil_pattern};

endmodule

### rtl/sths_front.sv
// Front end of the stepper speed drive: classifies a potentiometer request
// against the dead band and maps it to a hold time with a multiply and a
// radix-8 restoring divide. Depends on sths_pkg.
`timescale 1ns / 1ps

module sths_front (
   input  logic                    clock,
   input  logic                    reset,
   input  sths_pkg::cfg_type       cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [9:0]              pot_sample,
   output logic                    push,
   input  logic                    queue_full,
   output sths_pkg::step_entry_type push_entry
);
   import sths_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam int DIV_BITS   = 15;
   localparam int DIV_CYCLES = DIV_BITS / 3;

   state_type   state_ff, state_in;
   dir_type     dir_ff, dir_in;
   logic [9:0]  n_ff, n_in;
   logic [9:0]  s_ff, s_in;
   logic [12:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [9:0]  rem_ff, rem_in;
   logic [14:0] dvd_ff, dvd_in;
   logic [14:0] quo_ff, quo_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [8:0]  half;
   logic [9:0]  upper, lower;
   logic        is_cw, is_ccw;
   logic [13:0] delta;
   logic [21:0] product;
   logic        zero_span;
   logic [13:0] q_signed;
   logic [13:0] hold_sum;

   // Three restoring divide steps per cycle
   function automatic logic [27:0] div_step3(input logic [9:0]  rem,
                                             input logic [14:0] dvd,
                                             input logic [14:0] quo,
                                             input logic [9:0]  dvs);
      logic [10:0] r;
      logic [14:0] d;
      logic [14:0] q;
      r = {1'b0, rem};
      d = dvd;
      q = quo;
      for (int j = 0; j < 3; j++) begin
         r = {r[9:0], d[14]};
         d = {d[13:0], 1'b0};
         if (r >= {1'b0, dvs}) begin
            r = r - {1'b0, dvs};
            q = {q[13:0], 1'b1};
         end else begin
            q = {q[13:0], 1'b0};
         end
      end
      return {r[9:0], d[2:0], q};
   endfunction

   logic [27:0] step_out;

   // Band edges and classification of the incoming request
   assign half   = cfg.dead_band[9:1];
   assign upper  = MID_SCALE + {1'b0, half};
   assign lower  = MID_SCALE - {1'b0, half};
   assign is_cw  = (pot_sample >= upper);
   assign is_ccw = !is_cw && (pot_sample <= lower);
   assign delta  = {1'b0, cfg.fastest_delay_us} - {1'b0, cfg.slowest_delay_us};

   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && !queue_full);
   assign accept    = req_valid && req_ready;
   assign push      = (state_ff == ST_DONE) && !queue_full;

   // Product of distance into the turn range and delay span magnitude
   assign product  = {12'd0, n_ff} * {9'd0, mag_ff};
   assign step_out = div_step3(rem_ff, dvd_ff, quo_ff, s_ff);

   // Signed quotient added onto the slowest delay; a zero span holds the slowest delay
   assign zero_span = (s_ff == 10'd0);
   assign q_signed  = zero_span ? 14'd0 :
                      (neg_ff ? (14'd0 - {1'b0, quo_ff[12:0]}) : {1'b0, quo_ff[12:0]});
   assign hold_sum  = {1'b0, cfg.slowest_delay_us} + q_signed;

   assign push_entry.hold_us   = (dir_ff == DIR_STOP) ? 13'd0 : hold_sum[12:0];
   assign push_entry.direction = dir_ff;

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      n_in     = n_ff;
      s_in     = s_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_DONE: begin
            if (accept) begin
               neg_in = delta[13];
               mag_in = delta[13] ? 13'(14'd0 - delta) : delta[12:0];
               if (is_cw) begin
                  dir_in   = DIR_CW;
                  n_in     = pot_sample - upper;
                  s_in     = FULL_SCALE - upper;
                  state_in = ST_MUL;
               end else if (is_ccw) begin
                  dir_in   = DIR_CCW;
                  n_in     = lower - pot_sample;
                  s_in     = lower;
                  state_in = ST_MUL;
               end else begin
                  dir_in   = DIR_STOP;
                  state_in = ST_DONE;
               end
            end else if (state_ff == ST_DONE && push) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            // Quotient stays below 2^13, so the top bits already sit below the divisor
            rem_in   = {3'd0, product[21:15]};
            dvd_in   = product[14:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = step_out[27:18];
            dvd_in = {step_out[17:15], 12'd0} | (dvd_ff << 3);
            quo_in = step_out[14:0];
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(DIV_CYCLES - 1)) begin
               state_in = ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and operand registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dir_ff   <= DIR_STOP;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
         cnt_ff   <= cnt_in;
      end
      n_ff   <= n_in;
      s_ff   <= s_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

endmodule

### rtl/sths_queue.sv
// Two-entry queue between the front and back ends of the stepper drive.
// Holds classified requests (hold time and direction). Depends on sths_pkg.
`timescale 1ns / 1ps

module sths_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sths_pkg::step_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output sths_pkg::step_entry_type head
);
   import sths_pkg::*;

   step_entry_type mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/sths_back.sv
// Back end of the stepper drive: walks the half-step table for the queue
// head and drives the registered response stream. Depends on sths_pkg.
`timescale 1ns / 1ps

module sths_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  sths_pkg::step_entry_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               coil_pattern,
   output logic [12:0]              hold_us,
   output logic [1:0]               direction,
   output logic                     last
);
   import sths_pkg::*;

   logic        valid_ff, valid_in;
   logic [2:0]  k_ff, k_in;
   logic [3:0]  pat_ff;
   logic [12:0] hold_ff;
   logic [1:0]  dir_ff;
   logic        last_ff;

   logic        load;
   logic        is_last;
   logic [2:0]  idx;

   // Output register takes a new step when free or being drained
   assign load    = !empty && (!valid_ff || rsp_ready);
   assign is_last = (head.direction == DIR_STOP) || (k_ff == 3'(HALF_STEPS - 1));
   assign idx     = (head.direction == DIR_CW) ? (3'(HALF_STEPS - 1) - k_ff) : k_ff;
   assign pop     = load && is_last;

   always_comb begin
      valid_in = valid_ff;
      k_in     = k_ff;
      if (load) begin
         valid_in = 1'b1;
         k_in     = is_last ? 3'd0 : k_ff + 3'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
      if (load) begin
         pat_ff  <= (head.direction == DIR_STOP) ? 4'b0000 : half_step_pattern(idx);
         hold_ff <= head.hold_us;
         dir_ff  <= head.direction;
         last_ff <= is_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign coil_pattern = pat_ff;
   assign hold_us      = hold_ff;
   assign direction    = dir_ff;
   assign last         = last_ff;

endmodule
